FILE: hw/rtl/gpp_pkg.sv
// Shared types, constants and fixed-point helpers for the ground-plane projection block.
`timescale 1ns / 1ps

package gpp_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PITCH_W    = FRAC_BITS + 1;
   localparam int ULEN_W     = DATA_WIDTH - 1;
   localparam int OPB_W      = DATA_WIDTH + 1;
   localparam int PROD_W     = DATA_WIDTH + OPB_W;
   localparam int SHR_W      = PROD_W - FRAC_BITS;
   localparam int DVD_W      = DATA_WIDTH + FRAC_BITS;
   localparam int DIV_STEPS  = DVD_W;
   localparam int REG_NUM    = 8;
   localparam int CSR_DW     = 32;
   localparam int CSR_AW     = $clog2(REG_NUM * 4);
   localparam int REQ_DW     = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_DW     = ((3 * DATA_WIDTH + 7) / 8) * 8;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic signed [OPB_W-1:0]      opb_type;
   typedef logic [PITCH_W-1:0]           pitch_type;
   typedef logic [ULEN_W-1:0]            ulen_type;

   localparam word_type  VMAX      = word_type'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam word_type  VMIN      = word_type'({1'b1, {(DATA_WIDTH-1){1'b0}}});
   localparam pitch_type PITCH_ONE = pitch_type'(1) << FRAC_BITS;
   localparam ulen_type  ULEN_ONE  = ulen_type'(1) << FRAC_BITS;

   typedef enum logic [$clog2(REG_NUM)-1:0] {
      REG_FOCAL, REG_HEIGHT, REG_SIN, REG_COS,
      REG_CX, REG_CY, REG_BACK, REG_HORIZON
   } reg_idx_type;

   // register values plus constants derived from them
   typedef struct packed {
      ulen_type  fl;
      ulen_type  h;
      pitch_type sin;
      pitch_type cos;
      word_type  cx;
      word_type  cy;
      word_type  bo;
      word_type  hr;
      word_type  fs;
      word_type  fc;
      word_type  hs;
      word_type  hfc;
      word_type  nbo;
   } cfg_type;

   typedef struct packed {
      logic     mode;
      logic     ok;
      word_type r0;
      word_type r1;
      word_type r2;
   } side_type;

   typedef struct packed {
      logic     valid;
      word_type num;
      word_type den;
      side_type side;
   } div_type;

   typedef struct packed {
      logic     valid;
      word_type quot;
      side_type side;
   } dres_type;

   typedef struct packed {
      logic     hit;
      word_type a;
      word_type b;
      word_type t;
   } rsp_type;

   function automatic word_type clip(input logic signed [DATA_WIDTH:0] s);
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         return s[DATA_WIDTH] ? VMIN : VMAX;
      end
      return s[DATA_WIDTH-1:0];
   endfunction

   function automatic word_type add_sat(input word_type a, input word_type b);
      logic signed [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      return clip(s);
   endfunction

   function automatic word_type sub_sat(input word_type a, input word_type b);
      logic signed [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      return clip(s);
   endfunction

   function automatic word_type neg_sat(input word_type a);
      logic signed [DATA_WIDTH:0] s;
      s = -{a[DATA_WIDTH-1], a};
      return clip(s);
   endfunction

   function automatic logic is_pos(input word_type x);
      return !x[DATA_WIDTH-1] && (|x);
   endfunction

   function automatic word_type len_word(input ulen_type x);
      return word_type'({1'b0, x});
   endfunction

   function automatic opb_type opb_s(input word_type x);
      return {x[DATA_WIDTH-1], x};
   endfunction

   function automatic opb_type opb_pitch(input pitch_type x);
      return opb_type'({{(OPB_W-PITCH_W){1'b0}}, x});
   endfunction

   function automatic opb_type opb_len(input ulen_type x);
      return opb_type'({{(OPB_W-ULEN_W){1'b0}}, x});
   endfunction

   // product shifted down by FRAC_BITS, rounded toward minus infinity, saturated
   function automatic word_type qmul(input word_type a, input opb_type b);
      logic signed [PROD_W-1:0] p;
      logic [SHR_W-1:0]         s;
      logic                     ovf;
      p   = PROD_W'(a) * PROD_W'(b);
      s   = p[PROD_W-1:FRAC_BITS];
      ovf = s[SHR_W-1:DATA_WIDTH-1] != {(SHR_W-DATA_WIDTH+1){s[SHR_W-1]}};
      if (ovf) begin
         return s[SHR_W-1] ? VMIN : VMAX;
      end
      return word_type'(s[DATA_WIDTH-1:0]);
   endfunction

   function automatic pitch_type clamp_pitch(input logic [CSR_DW-1:0] v);
      pitch_type p;
      p = v[PITCH_W-1:0];
      return (p > PITCH_ONE) ? PITCH_ONE : p;
   endfunction

endpackage

FILE: hw/rtl/ground_plane_perspective_projection.sv
// Both modes pass through the same stages from item acceptance to rsp_tvalid.
// Throughput: one item per cycle while the skid entry is empty; three pipelined dividers set the depth.
// The output register plus one skid entry decouple the sides; req_tready drops
// only while the skid entry holds an item.
// Reset (synchronous) empties the pipeline and loads the register reset values.
`timescale 1ns / 1ps

module ground_plane_perspective_projection (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [gpp_pkg::REQ_DW-1:0]  req_tdata,   // coord_a, coord_b
   input  logic [0:0]                  req_tuser,   // mode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [gpp_pkg::RSP_DW-1:0]  rsp_tdata,   // out_a, out_b, depth_scale
   output logic [0:0]                  rsp_tuser,   // hit
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gpp_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [gpp_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [gpp_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import gpp_pkg::*;

   cfg_type  cfg;
   logic     en;
   div_type  dv1, dv2, dv3;
   dres_type d1, d2, d3;

   assign req_tready = en;

   gpp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gpp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .take    (req_tvalid & en),
      .mode    (req_tuser[0]),
      .coord_a (word_type'(req_tdata[DATA_WIDTH-1:0])),
      .coord_b (word_type'(req_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
      .cfg     (cfg),
      .dv      (dv1)
   );

   gpp_div u_div1 (.clock(clock), .reset(reset), .en(en), .din(dv1), .dout(d1));

   gpp_mid u_mid (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .cfg   (cfg),
      .d1    (d1),
      .dv    (dv2)
   );

   gpp_div u_div2 (.clock(clock), .reset(reset), .en(en), .din(dv2), .dout(d2));

   // mode 1: keep the item only for a positive depth scale, then divide coord_b by it
   always_comb begin
      dv3.valid     = d2.valid;
      dv3.num       = d2.side.r0;
      dv3.den       = d2.quot;
      dv3.side.mode = d2.side.mode;
      dv3.side.ok   = d2.side.ok & (~d2.side.mode | is_pos(d2.quot));
      dv3.side.r0   = d2.side.r0;
      dv3.side.r1   = d2.side.r1;
      dv3.side.r2   = d2.quot;
   end

   gpp_div u_div3 (.clock(clock), .reset(reset), .en(en), .din(dv3), .dout(d3));

   gpp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .d3         (d3),
      .en         (en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: hw/rtl/gpp_csr.sv
// Configuration registers and the constants derived from them.
`timescale 1ns / 1ps

module gpp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gpp_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [gpp_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [gpp_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output gpp_pkg::cfg_type              cfg
);
   import gpp_pkg::*;

   ulen_type    fl_ff, h_ff;
   pitch_type   sin_ff, cos_ff;
   word_type    cx_ff, cy_ff, bo_ff, hr_ff;
   word_type    fs_ff, fc_ff, hs_ff, hfl_ff, hfc_ff, nbo_ff;
   logic        wr;
   reg_idx_type idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = reg_idx_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         fl_ff  <= ULEN_ONE;
         h_ff   <= ULEN_ONE;
         sin_ff <= PITCH_ONE;
         cos_ff <= '0;
         cx_ff  <= '0;
         cy_ff  <= '0;
         bo_ff  <= '0;
         hr_ff  <= '0;
      end else if (wr) begin
         case (idx)
            REG_FOCAL:   fl_ff  <= csr_pwdata[ULEN_W-1:0];
            REG_HEIGHT:  h_ff   <= csr_pwdata[ULEN_W-1:0];
            REG_SIN:     sin_ff <= clamp_pitch(csr_pwdata);
            REG_COS:     cos_ff <= clamp_pitch(csr_pwdata);
            REG_CX:      cx_ff  <= word_type'(csr_pwdata[DATA_WIDTH-1:0]);
            REG_CY:      cy_ff  <= word_type'(csr_pwdata[DATA_WIDTH-1:0]);
            REG_BACK:    bo_ff  <= word_type'(csr_pwdata[DATA_WIDTH-1:0]);
            REG_HORIZON: hr_ff  <= word_type'(csr_pwdata[DATA_WIDTH-1:0]);
            default: ;
         endcase
      end
   end

   // recomputed every cycle; the user must send items only well after a write, the block does not enforce it
   always_ff @(posedge clock) begin
      fs_ff  <= qmul(len_word(fl_ff), opb_pitch(sin_ff));
      fc_ff  <= qmul(len_word(fl_ff), opb_pitch(cos_ff));
      hs_ff  <= qmul(len_word(h_ff), opb_pitch(sin_ff));
      hfl_ff <= qmul(len_word(h_ff), opb_len(fl_ff));
      hfc_ff <= qmul(hfl_ff, opb_pitch(cos_ff));
      nbo_ff <= neg_sat(bo_ff);
   end

   always_comb begin
      case (idx)
         REG_FOCAL:   csr_prdata = CSR_DW'(fl_ff);
         REG_HEIGHT:  csr_prdata = CSR_DW'(h_ff);
         REG_SIN:     csr_prdata = CSR_DW'(sin_ff);
         REG_COS:     csr_prdata = CSR_DW'(cos_ff);
         REG_CX:      csr_prdata = CSR_DW'(cx_ff);
         REG_CY:      csr_prdata = CSR_DW'(cy_ff);
         REG_BACK:    csr_prdata = CSR_DW'(bo_ff);
         REG_HORIZON: csr_prdata = CSR_DW'(hr_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg = '{fl: fl_ff, h: h_ff, sin: sin_ff, cos: cos_ff,
                  cx: cx_ff, cy: cy_ff, bo: bo_ff, hr: hr_ff,
                  fs: fs_ff, fc: fc_ff, hs: hs_ff, hfc: hfc_ff, nbo: nbo_ff};

endmodule

FILE: hw/rtl/gpp_front.sv
// Front stages: offsets, first products and the numerator and denominator of the first quotient.
`timescale 1ns / 1ps

module gpp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                take,
   input  logic                mode,
   input  gpp_pkg::word_type   coord_a,
   input  gpp_pkg::word_type   coord_b,
   input  gpp_pkg::cfg_type    cfg,
   output gpp_pkg::div_type    dv
);
   import gpp_pkg::*;

   logic     s1_vld_ff, s1_mode_ff;
   word_type s1_x_ff, s1_u_ff, s1_b_ff, s1_x_in, s1_u_in;
   logic     s2_vld_ff, s2_mode_ff;
   word_type s2_pa_ff, s2_pb_ff, s2_u_ff, s2_b_ff, s2_pa_in, s2_pb_in;
   logic     s3_vld_ff, s3_mode_ff;
   word_type s3_c0_ff, s3_c1_ff, s3_u_ff, s3_b_ff, s3_c0_in, s3_c1_in;
   div_type  dv_ff, dv_in;

   always_comb begin
      s1_x_in = mode ? add_sat(coord_a, cfg.bo) : sub_sat(cfg.cy, coord_b);
      s1_u_in = sub_sat(coord_a, cfg.cx);

      s2_pa_in = qmul(s1_x_ff, opb_pitch(cfg.cos));
      s2_pb_in = qmul(s1_x_ff, s1_mode_ff ? opb_len(cfg.fl) : opb_pitch(cfg.sin));

      s3_c0_in = s2_mode_ff ? add_sat(s2_pa_ff, cfg.hs) : sub_sat(cfg.fs, s2_pa_ff);
      s3_c1_in = s2_mode_ff ? qmul(s2_pb_ff, opb_pitch(cfg.sin))
                            : add_sat(s2_pb_ff, cfg.fc);

      dv_in.valid     = s3_vld_ff;
      dv_in.side.mode = s3_mode_ff;
      dv_in.side.r1   = s3_u_ff;
      dv_in.side.r2   = '0;
      if (s3_mode_ff) begin
         dv_in.num     = sub_sat(cfg.hfc, s3_c1_ff);
         dv_in.den     = neg_sat(s3_c0_ff);
         dv_in.side.ok = |dv_in.den;
         dv_in.side.r0 = s3_b_ff;
      end else begin
         dv_in.num     = len_word(cfg.h);
         dv_in.den     = s3_c0_ff;
         dv_in.side.ok = is_pos(s3_c0_ff);
         dv_in.side.r0 = s3_c1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         dv_ff.valid <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= take;
         s1_mode_ff <= mode;
         s1_x_ff    <= s1_x_in;
         s1_u_ff    <= s1_u_in;
         s1_b_ff    <= coord_b;
         s2_vld_ff  <= s1_vld_ff;
         s2_mode_ff <= s1_mode_ff;
         s2_pa_ff   <= s2_pa_in;
         s2_pb_ff   <= s2_pb_in;
         s2_u_ff    <= s1_u_ff;
         s2_b_ff    <= s1_b_ff;
         s3_vld_ff  <= s2_vld_ff;
         s3_mode_ff <= s2_mode_ff;
         s3_c0_ff   <= s3_c0_in;
         s3_c1_ff   <= s3_c1_in;
         s3_u_ff    <= s2_u_ff;
         s3_b_ff    <= s2_b_ff;
         dv_ff      <= dv_in;
      end
   end

   assign dv = dv_ff;

endmodule

FILE: hw/rtl/gpp_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage, saturated.
`timescale 1ns / 1ps

module gpp_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  gpp_pkg::div_type   din,
   output gpp_pkg::dres_type  dout
);
   import gpp_pkg::*;

   typedef struct packed {
      logic                  vld;
      logic                  neg;
      logic                  dz;
      logic                  npos;
      logic                  nneg;
      logic [DATA_WIDTH-1:0] dvs;
      logic [DATA_WIDTH-1:0] rem;
      logic [DVD_W-1:0]      quo;
      side_type              side;
   } dstg_type;

   dstg_type stg_ff [0:DIV_STEPS];
   dstg_type stg_in [0:DIV_STEPS];
   dres_type out_ff, out_in;

   always_comb begin
      logic [DATA_WIDTH:0]   trial;
      logic [DATA_WIDTH-1:0] nmag;
      logic [DATA_WIDTH-1:0] dmag;
      nmag = din.num[DATA_WIDTH-1] ? (~din.num + 1'b1) : din.num;
      dmag = din.den[DATA_WIDTH-1] ? (~din.den + 1'b1) : din.den;
      stg_in[0].vld  = din.valid;
      stg_in[0].neg  = din.num[DATA_WIDTH-1] ^ din.den[DATA_WIDTH-1];
      stg_in[0].dz   = ~|din.den;
      stg_in[0].npos = is_pos(din.num);
      stg_in[0].nneg = din.num[DATA_WIDTH-1];
      stg_in[0].dvs  = dmag;
      stg_in[0].rem  = '0;
      stg_in[0].quo  = {nmag, {FRAC_BITS{1'b0}}};
      stg_in[0].side = din.side;
      for (int k = 0; k < DIV_STEPS; k++) begin
         stg_in[k+1] = stg_ff[k];
         trial = {stg_ff[k].rem, stg_ff[k].quo[DVD_W-1]} - {1'b0, stg_ff[k].dvs};
         stg_in[k+1].quo = {stg_ff[k].quo[DVD_W-2:0], ~trial[DATA_WIDTH]};
         if (!trial[DATA_WIDTH]) begin
            stg_in[k+1].rem = trial[DATA_WIDTH-1:0];
         end else begin
            stg_in[k+1].rem = {stg_ff[k].rem[DATA_WIDTH-2:0], stg_ff[k].quo[DVD_W-1]};
         end
      end
   end

   always_comb begin
      logic [DVD_W-1:0] q;
      q = stg_ff[DIV_STEPS].quo;
      out_in.valid = stg_ff[DIV_STEPS].vld;
      out_in.side  = stg_ff[DIV_STEPS].side;
      if (stg_ff[DIV_STEPS].dz) begin
         out_in.quot = stg_ff[DIV_STEPS].npos ? VMAX :
                       (stg_ff[DIV_STEPS].nneg ? VMIN : '0);
      end else if (stg_ff[DIV_STEPS].neg) begin
         // magnitude above 2^(W-1) pins to the most negative value
         if ((|q[DVD_W-1:DATA_WIDTH]) || (q[DATA_WIDTH-1] && (|q[DATA_WIDTH-2:0]))) begin
            out_in.quot = VMIN;
         end else begin
            out_in.quot = word_type'(~q[DATA_WIDTH-1:0] + 1'b1);
         end
      end else begin
         out_in.quot = (|q[DVD_W-1:DATA_WIDTH-1]) ? VMAX : word_type'(q[DATA_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            stg_ff[k].vld <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (en) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign dout = out_ff;

endmodule

FILE: hw/rtl/gpp_mid.sv
// Middle stages: horizon test, products on the first quotient and the second denominator.
`timescale 1ns / 1ps

module gpp_mid (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  gpp_pkg::cfg_type   cfg,
   input  gpp_pkg::dres_type  d1,
   output gpp_pkg::div_type   dv
);
   import gpp_pkg::*;

   logic     e_vld_ff, e_mode_ff, e_ok_ff, e_ok_in;
   word_type e_pa_ff, e_pb_ff, e_v_ff, e_b_ff, e_pa_in, e_pb_in;
   word_type tt;
   div_type  dv_ff, dv_in;

   always_comb begin
      e_ok_in = d1.side.ok;
      // drop mode 1 items that land at or above the horizon while cos is nonzero
      if (d1.side.mode && (|cfg.cos) && (d1.quot >= cfg.hr)) begin
         e_ok_in = 1'b0;
      end
      e_pa_in = qmul(d1.quot, d1.side.mode ? opb_pitch(cfg.cos) : opb_s(d1.side.r0));
      e_pb_in = qmul(d1.quot, opb_s(d1.side.r1));

      tt = sub_sat(cfg.fs, e_pa_ff);
      dv_in.valid     = e_vld_ff;
      dv_in.num       = len_word(cfg.h);
      dv_in.den       = tt;
      dv_in.side.mode = e_mode_ff;
      dv_in.side.r2   = '0;
      if (e_mode_ff) begin
         dv_in.side.ok = e_ok_ff & is_pos(tt);
         dv_in.side.r0 = e_b_ff;
         dv_in.side.r1 = e_v_ff;
      end else begin
         dv_in.side.ok = e_ok_ff;
         dv_in.side.r0 = add_sat(cfg.nbo, e_pa_ff);
         dv_in.side.r1 = e_pb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff    <= 1'b0;
         dv_ff.valid <= 1'b0;
      end else if (en) begin
         e_vld_ff  <= d1.valid;
         e_mode_ff <= d1.side.mode;
         e_ok_ff   <= e_ok_in;
         e_pa_ff   <= e_pa_in;
         e_pb_ff   <= e_pb_in;
         e_v_ff    <= d1.quot;
         e_b_ff    <= d1.side.r0;
         dv_ff     <= dv_in;
      end
   end

   assign dv = dv_ff;

endmodule

FILE: hw/rtl/gpp_out.sv
// Result assembly and the output register with its skid entry.
`timescale 1ns / 1ps

module gpp_out (
   input  logic                        clock,
   input  logic                        reset,
   input  gpp_pkg::cfg_type            cfg,
   input  gpp_pkg::dres_type           d3,
   output logic                        en,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [gpp_pkg::RSP_DW-1:0]  rsp_tdata,
   output logic [0:0]                  rsp_tuser
);
   import gpp_pkg::*;

   rsp_type res;
   rsp_type out_ff, skd_ff;
   logic    out_vld_ff, skd_vld_ff, take;

   always_comb begin
      res.hit = d3.side.ok;
      if (d3.side.mode) begin
         res.a = add_sat(cfg.cx, d3.quot);
         res.b = sub_sat(cfg.cy, d3.side.r1);
         res.t = d3.side.r2;
      end else begin
         res.a = d3.side.r0;
         res.b = d3.side.r1;
         res.t = '0;
      end
      if (!d3.side.ok) begin
         res.a = '0;
         res.b = '0;
         res.t = '0;
      end
   end

   // pipeline moves only while the skid entry is empty
   assign en   = ~skd_vld_ff;
   assign take = en & d3.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skd_vld_ff <= 1'b0;
      end else if (skd_vld_ff) begin
         if (rsp_tready) begin
            out_ff     <= skd_ff;
            skd_vld_ff <= 1'b0;
         end
      end else if (take) begin
         if (!out_vld_ff || rsp_tready) begin
            out_ff     <= res;
            out_vld_ff <= 1'b1;
         end else begin
            skd_ff     <= res;
            skd_vld_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = RSP_DW'({out_ff.t, out_ff.b, out_ff.a});
   assign rsp_tuser[0] = out_ff.hit;

endmodule

FILE: tb/ground_plane_perspective_projection_tb.sv
// Self-checking testbench for the ground-plane perspective projection block.
`timescale 1ns / 1ps

module ground_plane_perspective_projection_tb;
   import gpp_pkg::*;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam longint QONE = 64'sd65536;

   typedef struct {
      logic     mode;
      word_type a;
      word_type b;
      bit       typed;
      rsp_type  want;
   } row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata = '0;
   logic [0:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [0:0]          rsp_tuser;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   rsp_type pending_proj[$];
   int      error_count = 0;
   int      sent_count = 0;
   bit      long_hold_done = 0;

   // projection settings as the block should hold them
   longint focal, height, sin_p, cos_p, ctr_x, ctr_y, back_off, horizon;

   ground_plane_perspective_projection dut (.*);

   always #6 clock = ~clock;

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   function automatic longint clamp_w(longint v);
      return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
   endfunction

   // product floored after dropping the fraction bits
   function automatic longint prod_q(longint a, longint b);
      longint p;
      p = a * b;
      return clamp_w(p >>> FRAC_BITS);
   endfunction

   // quotient truncated toward zero
   function automatic longint quot_q(longint a, longint b);
      if (b == 0) begin
         return a > 0 ? WMAX : (a < 0 ? WMIN : 0);
      end
      return clamp_w((a * QONE) / b);
   endfunction

   function automatic rsp_type project(logic mode, word_type ca, word_type cb);
      longint  a, b, ra, rb, rt, fs, u, v, den, t, k, y, n1, n2, tt;
      bit      ok;
      rsp_type r;
      a = ca;
      b = cb;
      ra = 0;
      rb = 0;
      rt = 0;
      ok = 0;
      fs = prod_q(focal, sin_p);
      if (mode == 1'b0) begin
         u = clamp_w(a - ctr_x);
         v = clamp_w(ctr_y - b);
         den = clamp_w(fs - prod_q(v, cos_p));
         if (den > 0) begin
            t = quot_q(height, den);
            k = clamp_w(prod_q(v, sin_p) + prod_q(focal, cos_p));
            ra = clamp_w(clamp_w(-back_off) + prod_q(t, k));
            rb = prod_q(t, u);
            ok = 1;
         end
      end else begin
         y = clamp_w(a + back_off);
         den = clamp_w(-clamp_w(prod_q(y, cos_p) + prod_q(height, sin_p)));
         if (den != 0) begin
            n1 = prod_q(prod_q(height, focal), cos_p);
            n2 = prod_q(prod_q(y, focal), sin_p);
            v = quot_q(clamp_w(n1 - n2), den);
            // rows at or above the horizon have no ground point
            if (!(cos_p != 0 && v >= horizon)) begin
               tt = clamp_w(fs - prod_q(v, cos_p));
               if (tt > 0) begin
                  tt = quot_q(height, tt);
                  if (tt > 0) begin
                     ra = clamp_w(ctr_x + quot_q(b, tt));
                     rb = clamp_w(ctr_y - v);
                     rt = tt;
                     ok = 1;
                  end
               end
            end
         end
      end
      r.hit = ok;
      r.a = ok ? word_type'(ra) : '0;
      r.b = ok ? word_type'(rb) : '0;
      r.t = ok ? word_type'(rt) : '0;
      return r;
   endfunction

   task automatic report_mismatch(string what, word_type got, word_type want);
      $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_reg(reg_idx_type idx, logic [31:0] v);
      longint p;
      p = v[PITCH_W-1:0];
      if (p > QONE) p = QONE;
      case (idx)
         REG_FOCAL:   focal = v[ULEN_W-1:0];
         REG_HEIGHT:  height = v[ULEN_W-1:0];
         REG_SIN:     sin_p = p;
         REG_COS:     cos_p = p;
         REG_CX:      ctr_x = word_type'(v);
         REG_CY:      ctr_y = word_type'(v);
         REG_BACK:    back_off = word_type'(v);
         REG_HORIZON: horizon = word_type'(v);
         default: ;
      endcase
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(idx * 4);
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      // idle before the next transfer
      @(posedge clock);
   endtask

   task automatic send_item(logic mode, word_type a, word_type b, bit typed, rsp_type want);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {b, a};
      do @(posedge clock); while (!req_tready);
      pending_proj.push_back(typed ? want : project(mode, a, b));
      sent_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_proj.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function automatic word_type pick_coord(bit near);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return VMAX;
            1: return VMIN;
            2: return '0;
            default: return word_type'(-1);
         endcase
      end
      if (r < 4 || !near) return word_type'($urandom);
      return word_type'(int'($urandom_range(0, 200 << 16)) - (100 << 16));
   endfunction

   // receiver: random stalls, one long hold to back the pipeline up
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (!long_hold_done && sent_count >= 300) begin
            long_hold_done = 1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         n = gap_len();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_proj.size() == 0) begin
            $display("%0t: result with no item outstanding", $realtime);
            error_count++;
         end else begin
            want = pending_proj.pop_front();
            if (rsp_tuser[0] !== want.hit)
               report_mismatch("hit", word_type'(rsp_tuser[0]), word_type'(want.hit));
            if (rsp_tdata[31:0] !== want.a)
               report_mismatch("out_a", rsp_tdata[31:0], want.a);
            if (rsp_tdata[63:32] !== want.b)
               report_mismatch("out_b", rsp_tdata[63:32], want.b);
            if (rsp_tdata[95:64] !== want.t)
               report_mismatch("depth_scale", rsp_tdata[95:64], want.t);
         end
      end
   end

   initial begin
      row_type  rows[$];
      row_type  rw;
      rsp_type  none;
      logic [31:0] cfg[8];
      bit       near;
      none = '{hit: 1'b0, a: '0, b: '0, t: '0};
      focal = QONE;
      height = QONE;
      sin_p = QONE;
      cos_p = 0;
      ctr_x = 0;
      ctr_y = 0;
      back_off = 0;
      horizon = 0;

      // values after reset can be read off directly
      rows.push_back('{1'b0, 32'h0, 32'h0, 1, '{1'b1, 32'h0, 32'h0, 32'h0}});
      rows.push_back('{1'b1, 32'h0, 32'h0, 1, '{1'b1, 32'h0, 32'h0, 32'h10000}});
      rows.push_back('{1'b0, 32'h10000, 32'h0, 1, '{1'b1, 32'h0, 32'h10000, 32'h0}});
      rows.push_back('{1'b0, 32'h0, 32'hFFFE0000, 1, '{1'b1, 32'h20000, 32'h0, 32'h0}});
      rows.push_back('{1'b0, VMAX, VMAX, 0, none});
      rows.push_back('{1'b0, VMIN, VMIN, 0, none});
      rows.push_back('{1'b0, VMAX, VMIN, 0, none});
      rows.push_back('{1'b1, VMAX, VMAX, 0, none});
      rows.push_back('{1'b1, VMIN, VMIN, 0, none});
      rows.push_back('{1'b1, VMIN, VMAX, 0, none});
      rows.push_back('{1'b1, 32'hFFFF0000, 32'h7FFF, 0, none});
      rows.push_back('{1'b0, 32'h1, 32'hFFFFFFFF, 0, none});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         rw = rows[i];
         send_item(rw.mode, rw.a, rw.b, rw.typed, rw.want);
      end
      drain();

      // more directed rows with a tilted camera and a horizon in view
      write_reg(REG_FOCAL, 32'd500 << 16);
      write_reg(REG_HEIGHT, 32'h18000);
      write_reg(REG_SIN, 32'd6540);
      write_reg(REG_COS, 32'd65209);
      write_reg(REG_HORIZON, 32'd20 << 16);
      send_item(1'b1, 32'd10 << 16, 32'd2 << 16, 0, none);
      send_item(1'b1, 32'd2000 << 16, 32'h0, 0, none);
      send_item(1'b1, 32'hFFF60000, 32'h0, 0, none);
      send_item(1'b0, 32'h0, 32'd100 << 16, 0, none);
      send_item(1'b0, 32'h0, 32'hFF9C0000, 0, none);
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         near = 1;
         case (ph)
            0: cfg = '{32'd500 << 16, 32'h18000, 32'd6540, 32'd65209,
                       32'd320 << 16, 32'd240 << 16, 32'd3 << 16, 32'd10 << 16};
            1: cfg = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h10000, 32'h10000,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
            2: cfg = '{32'h0, 32'h0, 32'h0, 32'h0,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
            // pitch above one and junk in the upper bits must be masked
            3: cfg = '{32'hFFFFFFFF, 32'h80000001, 32'hFFFFFFFF, 32'h1FFFF,
                       32'hFFFFFFFF, 32'h1, 32'hFFFF0000, 32'h0};
            4: cfg = '{32'd800 << 16, 32'h20000, 32'd20000, 32'd62400,
                       32'h0, 32'h0, 32'hFFFF0000, 32'd50 << 16};
            default: begin
               foreach (cfg[j]) cfg[j] = $urandom;
               near = $urandom_range(0, 1);
            end
         endcase
         for (int j = 0; j < 8; j++) write_reg(reg_idx_type'(j), cfg[j]);
         repeat (100) send_item(logic'($urandom_range(0, 1)), pick_coord(near),
                                pick_coord(near), 0, none);
         drain();
      end

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
